[rtl/core/acfr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package acfr_pkg;

    localparam int COUNT_W = 48;
    localparam int LEN_W   = 31;
    localparam int ID_W    = 32;
    localparam int ACT_W   = 3;

    localparam logic [LEN_W-1:0] FRAME_LENGTH_RST = 31'd262144;

    localparam logic [ACT_W-1:0] ACT_DISCARD   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_APPEND    = 3'd1;
    localparam logic [ACT_W-1:0] ACT_FIRST     = 3'd2;
    localparam logic [ACT_W-1:0] ACT_COMPLETE  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_MALFORMED = 3'd4;

    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [LEN_W-1:0]   len_t;

    // control between the sequencer and the remainder unit
    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } rem_ctrl_t;

endpackage

`default_nettype wire

[rtl/core/adc_capture_frame_reassembler_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// ADC capture frame reassembler. Each transaction on the slave side carries the
// 48-bit count of payload bytes sent before a packet of PAYLOAD_BYTES bytes; one
// result transaction follows on the master side, telling whether the packet is
// discarded, appended, opens the first frame, or closes the open frame (complete
// or malformed) and opens the next. From acceptance to result an item goes through
// a 48-step restoring remainder of the count by frame_length, one bit a cycle
// through a single shared subtractor, one more pass of that subtractor for the
// tail, and a final step that updates the frame state once the output is free.
// The block takes one item at a time; a waiting result does not block the next
// acceptance, only its completion. frame_length is written over APB at address
// 0 and must be written only while no item is in flight.
module adc_capture_frame_reassembler_unit
#(
    parameter int PAYLOAD_BYTES = 1456
)
(
    input  wire         clk,
    input  wire         rst_n,

    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    input  wire         s_tvalid,
    output logic        s_tready,
    // byte_count[47:0]
    input  wire  [47:0] s_tdata,

    output logic        m_tvalid,
    input  wire         m_tready,
    // action[2:0], tail_bytes, new_bytes, closed_frame_id[31:0],
    // closed_frame_total[31:0], open_frame_id[31:0], zero padding
    output logic [((3 + 2*$clog2(PAYLOAD_BYTES+1) + 96 + 7) / 8) * 8 - 1:0] m_tdata
);
    import acfr_pkg::*;

    localparam int CW    = $clog2(PAYLOAD_BYTES + 1);
    localparam int OUT_W = ACT_W + 2*CW + 3*ID_W;
    localparam int TD_W  = ((OUT_W + 7) / 8) * 8;
    localparam logic [CW-1:0] PAY_CW = CW'(PAYLOAD_BYTES);
    localparam logic [LEN_W:0] PAY_WIDE = (LEN_W+1)'(PAYLOAD_BYTES);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_BUSY = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]      state_reg, state_next;
    len_t            flen_reg;
    logic            started_reg, started_next;
    logic [ID_W-1:0] id_reg, id_next;
    logic [ID_W-1:0] total_reg, total_next;
    len_t            tail_reg;

    logic            mvalid_reg, mvalid_next;
    logic [OUT_W-1:0] mdata_reg, mdata_next;

    rem_ctrl_t       rem_st;
    len_t            rem_tail;
    logic            rem_start;
    logic            fin_go;

    logic            boundary;
    logic [CW-1:0]   tail_n, start_n;
    logic [ID_W:0]   close_sum, app_sum;
    logic [ID_W-1:0] close_total, app_total;
    logic [ACT_W-1:0] act;
    logic [CW-1:0]   out_tail, out_new;
    logic [ID_W-1:0] out_cid, out_ctot;

    // configuration port
    assign pready = 1'b1;

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == 1'b0)
        begin
            prdata = {1'b0, flen_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flen_reg <= FRAME_LENGTH_RST;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0))
        begin
            flen_reg <= pwdata[LEN_W-1:0];
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign rem_start = s_tvalid && s_tready;

    acfr_rem_unit u_rem
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (rem_start),
        .count        (s_tdata),
        .frame_length (flen_reg),
        .status       (rem_st),
        .tail         (rem_tail)
    );

    always_ff @(posedge clk)
    begin
        if (rem_st.done)
        begin
            tail_reg <= rem_tail;
        end
    end

    // frame decision
    always_comb
    begin
        boundary    = ({1'b0, tail_reg} < PAY_WIDE);
        tail_n      = tail_reg[CW-1:0];
        start_n     = PAY_CW - tail_n;
        close_sum   = {1'b0, total_reg} + (ID_W+1)'({tail_n[CW-1:1], 1'b0});
        close_total = close_sum[ID_W] ? '1 : close_sum[ID_W-1:0];
        app_sum     = {1'b0, total_reg} + (ID_W+1)'({PAY_CW[CW-1:1], 1'b0});
        app_total   = app_sum[ID_W] ? '1 : app_sum[ID_W-1:0];

        started_next = started_reg;
        id_next      = id_reg;
        total_next   = total_reg;
        act          = ACT_DISCARD;
        out_tail     = '0;
        out_new      = '0;
        out_cid      = '0;
        out_ctot     = '0;

        if (boundary)
        begin
            if (started_reg)
            begin
                out_cid  = id_reg;
                out_ctot = close_total;
                act      = (close_total == {1'b0, flen_reg}) ? ACT_COMPLETE : ACT_MALFORMED;
                id_next  = id_reg + 1'b1;
            end
            else
            begin
                act          = ACT_FIRST;
                id_next      = '0;
                started_next = 1'b1;
            end
            out_tail   = tail_n;
            out_new    = start_n;
            total_next = ID_W'({start_n[CW-1:1], 1'b0});
        end
        else if (started_reg)
        begin
            act        = ACT_APPEND;
            out_new    = PAY_CW;
            total_next = app_total;
        end
    end

    assign fin_go = (state_reg == ST_FIN) && (!mvalid_reg || m_tready);

    always_comb
    begin
        state_next  = state_reg;
        mvalid_next = mvalid_reg;
        mdata_next  = mdata_reg;
        if (mvalid_reg && m_tready)
        begin
            mvalid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (rem_start)
                begin
                    state_next = ST_BUSY;
                end
            end
            ST_BUSY:
            begin
                if (rem_st.done)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                // hold until the output register is free
                if (fin_go)
                begin
                    mvalid_next = 1'b1;
                    mdata_next  = {id_next, out_ctot, out_cid, out_new, out_tail, act};
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            mvalid_reg  <= 1'b0;
            started_reg <= 1'b0;
            id_reg      <= '0;
            total_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
            if (fin_go)
            begin
                started_reg <= started_next;
                id_reg      <= id_next;
                total_reg   <= total_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mdata_reg <= mdata_next;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = TD_W'(mdata_reg);

endmodule

`default_nettype wire

[rtl/core/acfr_rem_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

module acfr_rem_unit
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  start,
    input  wire acfr_pkg::count_t count,
    input  wire acfr_pkg::len_t  frame_length,
    output acfr_pkg::rem_ctrl_t  status,
    output acfr_pkg::len_t       tail
);
    import acfr_pkg::*;

    localparam int STEP_W = $clog2(COUNT_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(COUNT_W - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_TAIL = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              done_reg, done_next;
    count_t            dvd_reg, dvd_next;
    len_t              rem_reg, rem_next;
    len_t              tail_reg, tail_next;

    len_t              flen;
    logic [LEN_W:0]    sub_a, sub_b;
    logic [LEN_W+1:0]  diff;
    logic              borrow;

    assign flen = (frame_length == '0) ? len_t'(1) : frame_length;

    // shared subtractor: division steps, then the final flen - remainder
    always_comb
    begin
        if (state_reg == ST_TAIL)
        begin
            sub_a = {1'b0, flen};
            sub_b = {1'b0, rem_reg};
        end
        else
        begin
            sub_a = {rem_reg, dvd_reg[COUNT_W-1]};
            sub_b = {1'b0, flen};
        end
        diff   = {1'b0, sub_a} - {1'b0, sub_b};
        borrow = diff[LEN_W+1];
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        done_next  = 1'b0;
        dvd_next   = dvd_reg;
        rem_next   = rem_reg;
        tail_next  = tail_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    dvd_next   = count;
                    rem_next   = '0;
                    step_next  = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_next  = borrow ? sub_a[LEN_W-1:0] : diff[LEN_W-1:0];
                dvd_next  = {dvd_reg[COUNT_W-2:0], 1'b0};
                step_next = step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    state_next = ST_TAIL;
                end
            end
            ST_TAIL:
            begin
                tail_next  = (rem_reg == '0) ? '0 : diff[LEN_W-1:0];
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        tail_reg <= tail_next;
    end

    assign status.start = start;
    assign status.busy  = (state_reg != ST_IDLE);
    assign status.done  = done_reg;
    assign tail         = tail_reg;

endmodule

`default_nettype wire
